// ----- rtl/alc_pkg.sv -----
`default_nettype none

package alc_pkg;

  // Field widths
  localparam int unsigned TempW  = 9;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned RpmW   = 15;
  localparam int unsigned MinRpmW = 12;  // min_rpm_div10 * 10 fits in 12 bits
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Configuration register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    RegCoolantCut   = 3'd0,
    RegThrottleCut  = 3'd1,
    RegMinRpmDiv10  = 3'd2,
    RegMaxRpmDiv100 = 3'd3,
    RegCompOnDelay  = 3'd4,
    RegThrRelDelay  = 3'd5,
    RegRpmRelDelay  = 3'd6,
    RegStartDelay   = 3'd7
  } reg_idx_e;

  // Register reset values
  localparam logic signed [TempW-1:0] CoolantCutRst = 9'sd100;
  localparam logic [ByteW-1:0]        ThrottleCutRst = 8'd180;
  localparam logic [ByteW-1:0]        MinRpmDiv10Rst = 8'd50;
  localparam logic [ByteW-1:0]        MaxRpmDiv100Rst = 8'd60;

  // One control tick
  typedef struct packed {
    logic signed [TempW-1:0] coolant_temp;
    logic [ByteW-1:0]        throttle;
    logic [RpmW-1:0]         rpm;
    logic [ByteW-1:0]        rpm_div100;
    logic                    engine_running;
    logic                    ac_request;
  } tick_t;

  // One result
  typedef struct packed {
    logic compressor_on;
    logic fan_on;
    logic turning_on;
    logic coolant_lockout;
    logic throttle_lockout;
    logic rpm_lockout;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/alc_stream_if.sv -----
`default_nettype none

// Input channel: one control tick per transfer
interface alc_tick_if;
  import alc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] coolant_temp;
  logic [ByteW-1:0]        throttle;
  logic [RpmW-1:0]         rpm;
  logic [ByteW-1:0]        rpm_div100;
  logic                    engine_running;
  logic                    ac_request;

  modport source (
    output valid, coolant_temp, throttle, rpm, rpm_div100, engine_running, ac_request,
    input  ready
  );
  modport sink (
    input  valid, coolant_temp, throttle, rpm, rpm_div100, engine_running, ac_request,
    output ready
  );
endinterface

// Output channel: one result per transfer
interface alc_result_if;
  logic valid;
  logic ready;
  logic compressor_on;
  logic fan_on;
  logic turning_on;
  logic coolant_lockout;
  logic throttle_lockout;
  logic rpm_lockout;

  modport source (
    output valid, compressor_on, fan_on, turning_on, coolant_lockout,
           throttle_lockout, rpm_lockout,
    input  ready
  );
  modport sink (
    input  valid, compressor_on, fan_on, turning_on, coolant_lockout,
           throttle_lockout, rpm_lockout,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/aircon_lockout_controller.sv -----
// An accepted tick is held in the input register; its result is then registered in the result register.
// Throughput: one tick per cycle; the input register refills while the result register
// drains, so the block only stalls when the result register is full and not taken.
// All state updates happen in the one combinational pass between the two registers.
// Reset (rst_ni low, asynchronous): lockout flags, delay counters, A/C flags and both
// valid bits clear; configuration registers return to their documented defaults.
`default_nettype none

module aircon_lockout_controller (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  alc_tick_if.sink                    in_i,
  alc_result_if.source                out_o,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [alc_pkg::AddrW-1:0]    paddr,
  input  wire [alc_pkg::DataW-1:0]    pwdata,
  output logic [alc_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import alc_pkg::*;

  // Configuration registers
  logic signed [TempW-1:0] coolant_cut_q;
  logic [ByteW-1:0] throttle_cut_q, min_rpm_div10_q, max_rpm_div100_q;
  logic [ByteW-1:0] comp_on_delay_q, thr_rel_delay_q, rpm_rel_delay_q, start_delay_q;

  reg_idx_e reg_idx;
  logic     cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coolant_cut_q    <= CoolantCutRst;
      throttle_cut_q   <= ThrottleCutRst;
      min_rpm_div10_q  <= MinRpmDiv10Rst;
      max_rpm_div100_q <= MaxRpmDiv100Rst;
      comp_on_delay_q  <= '0;
      thr_rel_delay_q  <= '0;
      rpm_rel_delay_q  <= '0;
      start_delay_q    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegCoolantCut:   coolant_cut_q    <= $signed(pwdata[TempW-1:0]);
        RegThrottleCut:  throttle_cut_q   <= pwdata[ByteW-1:0];
        RegMinRpmDiv10:  min_rpm_div10_q  <= pwdata[ByteW-1:0];
        RegMaxRpmDiv100: max_rpm_div100_q <= pwdata[ByteW-1:0];
        RegCompOnDelay:  comp_on_delay_q  <= pwdata[ByteW-1:0];
        RegThrRelDelay:  thr_rel_delay_q  <= pwdata[ByteW-1:0];
        RegRpmRelDelay:  rpm_rel_delay_q  <= pwdata[ByteW-1:0];
        RegStartDelay:   start_delay_q    <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      RegCoolantCut:   prdata = DataW'(coolant_cut_q);
      RegThrottleCut:  prdata = DataW'(throttle_cut_q);
      RegMinRpmDiv10:  prdata = DataW'(min_rpm_div10_q);
      RegMaxRpmDiv100: prdata = DataW'(max_rpm_div100_q);
      RegCompOnDelay:  prdata = DataW'(comp_on_delay_q);
      RegThrRelDelay:  prdata = DataW'(thr_rel_delay_q);
      RegRpmRelDelay:  prdata = DataW'(rpm_rel_delay_q);
      RegStartDelay:   prdata = DataW'(start_delay_q);
      default:         prdata = '0;
    endcase
  end

  // Input register and result register handshake
  tick_t   in_q;
  logic    in_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    advance;

  assign advance     = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready  = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.coolant_temp   <= in_i.coolant_temp;
      in_q.throttle       <= in_i.throttle;
      in_q.rpm            <= in_i.rpm;
      in_q.rpm_div100     <= in_i.rpm_div100;
      in_q.engine_running <= in_i.engine_running;
      in_q.ac_request     <= in_i.ac_request;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.compressor_on    = res_q.compressor_on;
  assign out_o.fan_on           = res_q.fan_on;
  assign out_o.turning_on       = res_q.turning_on;
  assign out_o.coolant_lockout  = res_q.coolant_lockout;
  assign out_o.throttle_lockout = res_q.throttle_lockout;
  assign out_o.rpm_lockout      = res_q.rpm_lockout;

  // Controller state
  logic coolant_lock_q, coolant_lock_d;
  logic thr_lock_q, thr_lock_d;
  logic rpm_lock_q, rpm_lock_d;
  logic [ByteW-1:0] thr_cnt_q, thr_cnt_d;
  logic [ByteW-1:0] rpm_cnt_q, rpm_cnt_d;
  logic [ByteW-1:0] comp_cnt_q, comp_cnt_d;
  logic [ByteW-1:0] run_cnt_q, run_cnt_d;
  logic comp_q, comp_d;
  logic fan_q, fan_d;

  logic signed [TempW:0] temp_ext, cut_ext, cut_m1;
  logic [MinRpmW-1:0]    min_rpm;
  logic                  waited, rpm_bad, allow;

  // One control tick: counters, lockouts, then A/C drive
  always_comb begin
    run_cnt_d      = run_cnt_q;
    coolant_lock_d = coolant_lock_q;
    thr_lock_d     = thr_lock_q;
    thr_cnt_d      = thr_cnt_q;
    rpm_lock_d     = rpm_lock_q;
    rpm_cnt_d      = rpm_cnt_q;
    comp_cnt_d     = comp_cnt_q;
    comp_d         = comp_q;
    fan_d          = fan_q;
    waited         = 1'b0;

    // post-start delay
    if (in_q.engine_running) begin
      if (run_cnt_q >= start_delay_q) begin
        waited = 1'b1;
      end else begin
        run_cnt_d = run_cnt_q + 8'd1;
      end
    end else begin
      run_cnt_d = '0;
    end

    // coolant hysteresis, one degree band
    temp_ext = {in_q.coolant_temp[TempW-1], in_q.coolant_temp};
    cut_ext  = {coolant_cut_q[TempW-1], coolant_cut_q};
    cut_m1   = cut_ext - 10'sd1;
    if (temp_ext > cut_ext) begin
      coolant_lock_d = 1'b1;
    end else if (temp_ext < cut_m1) begin
      coolant_lock_d = 1'b0;
    end

    // throttle lockout with release delay
    if (in_q.throttle > throttle_cut_q) begin
      thr_lock_d = 1'b1;
      thr_cnt_d  = '0;
    end else if (thr_lock_q) begin
      if (thr_cnt_q >= thr_rel_delay_q) begin
        thr_lock_d = 1'b0;
      end else begin
        thr_cnt_d = thr_cnt_q + 8'd1;
      end
    end else begin
      thr_cnt_d = '0;
    end

    // rpm window; minimum = min_rpm_div10 * 10
    min_rpm = {1'b0, min_rpm_div10_q, 3'b000} + {3'b000, min_rpm_div10_q, 1'b0};
    rpm_bad = (in_q.rpm < RpmW'(min_rpm)) || (in_q.rpm_div100 > max_rpm_div100_q);
    if (rpm_bad) begin
      rpm_lock_d = 1'b1;
      rpm_cnt_d  = '0;
    end else if (rpm_cnt_q >= rpm_rel_delay_q) begin
      rpm_lock_d = 1'b0;
    end else begin
      rpm_cnt_d = rpm_cnt_q + 8'd1;
    end

    // A/C drive
    allow = in_q.ac_request & waited & ~coolant_lock_d & ~thr_lock_d & ~rpm_lock_d;
    if (allow) begin
      fan_d = 1'b1;
      if (comp_cnt_q >= comp_on_delay_q) begin
        comp_d = 1'b1;
      end else begin
        comp_cnt_d = comp_cnt_q + 8'd1;
      end
    end else begin
      fan_d      = 1'b0;
      comp_d     = 1'b0;
      comp_cnt_d = '0;
    end

    res_d.compressor_on    = comp_d;
    res_d.fan_on           = fan_d;
    res_d.turning_on       = allow;
    res_d.coolant_lockout  = coolant_lock_d;
    res_d.throttle_lockout = thr_lock_d;
    res_d.rpm_lockout      = rpm_lock_d;
  end

  // State update, once per processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coolant_lock_q <= 1'b0;
      thr_lock_q     <= 1'b0;
      rpm_lock_q     <= 1'b0;
      thr_cnt_q      <= '0;
      rpm_cnt_q      <= '0;
      comp_cnt_q     <= '0;
      run_cnt_q      <= '0;
      comp_q         <= 1'b0;
      fan_q          <= 1'b0;
    end else if (advance) begin
      coolant_lock_q <= coolant_lock_d;
      thr_lock_q     <= thr_lock_d;
      rpm_lock_q     <= rpm_lock_d;
      thr_cnt_q      <= thr_cnt_d;
      rpm_cnt_q      <= rpm_cnt_d;
      comp_cnt_q     <= comp_cnt_d;
      run_cnt_q      <= run_cnt_d;
      comp_q         <= comp_d;
      fan_q          <= fan_d;
    end
  end

`ifndef NO_ASSERTIONS
  // compressor never runs without the fan
  a_comp_needs_fan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_q |-> fan_q)
    else $error("compressor flag set without fan flag");

  // on-delay counter only advances while A/C is granted
  a_comp_cnt_fan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (comp_cnt_q != '0) |-> fan_q)
    else $error("compressor on-delay count running while fan is off");

  // a granted result never carries a lockout
  a_turn_no_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.turning_on) |->
      !(res_q.coolant_lockout || res_q.throttle_lockout || res_q.rpm_lockout))
    else $error("turning_on with a lockout set");

  // input stalls only when a tick is held behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a blocked result");

  // a processed tick always shows up as a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed tick produced no result");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import alc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  // APB side
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  wire  [DataW-1:0] prdata;
  wire              pready;

  alc_tick_if   tick_bus ();
  alc_result_if drive_bus ();

  aircon_lockout_controller uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_bus),
    .out_o   (drive_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the configuration
  logic signed [TempW-1:0] cfg_cool_cut;
  logic [ByteW-1:0] cfg_thr_cut;
  logic [ByteW-1:0] cfg_min_rpm10;
  logic [ByteW-1:0] cfg_max_rpm100;
  logic [ByteW-1:0] cfg_comp_delay;
  logic [ByteW-1:0] cfg_thr_release;
  logic [ByteW-1:0] cfg_rpm_release;
  logic [ByteW-1:0] cfg_start_delay;

  // Controller state as we expect it
  logic cool_lock, thr_lock, rpm_lock;
  logic [ByteW-1:0] thr_cnt, rpm_cnt, comp_cnt, run_cnt;
  logic comp_flag, fan_flag;

  result_t     predicted_drive[$];
  result_t     want_drive;
  int unsigned err_count = 0;
  bit          gaps_on   = 1'b1;
  int unsigned noise_pct = 0;

  task automatic reset_model();
    cfg_cool_cut    = CoolantCutRst;
    cfg_thr_cut     = ThrottleCutRst;
    cfg_min_rpm10   = MinRpmDiv10Rst;
    cfg_max_rpm100  = MaxRpmDiv100Rst;
    cfg_comp_delay  = '0;
    cfg_thr_release = '0;
    cfg_rpm_release = '0;
    cfg_start_delay = '0;
    cool_lock = 1'b0;
    thr_lock  = 1'b0;
    rpm_lock  = 1'b0;
    thr_cnt   = '0;
    rpm_cnt   = '0;
    comp_cnt  = '0;
    run_cnt   = '0;
    comp_flag = 1'b0;
    fan_flag  = 1'b0;
  endtask

  // Saturating tick counter: true once the delay is reached, else count up
  function automatic logic delay_elapsed(inout logic [ByteW-1:0] cnt,
                                         input logic [ByteW-1:0] lim);
    if (cnt >= lim) return 1'b1;
    cnt = cnt + 8'd1;
    return 1'b0;
  endfunction

  // Advance the expected state by one tick and return the drive outputs
  function automatic result_t predict_drive(input tick_t t);
    result_t r;
    logic    warmed_up;
    logic    accepted;
    int      min_rpm;
    int      temp;
    int      cut;
    warmed_up = 1'b0;
    accepted  = 1'b0;
    min_rpm   = int'(cfg_min_rpm10) * 10;
    temp      = int'($signed(t.coolant_temp));
    cut       = int'($signed(cfg_cool_cut));

    if (t.engine_running) warmed_up = delay_elapsed(run_cnt, cfg_start_delay);
    else run_cnt = '0;

    // coolant hysteresis: cut and cut-1 hold the flag
    if (temp > cut) cool_lock = 1'b1;
    else if (temp < cut - 1) cool_lock = 1'b0;

    if (t.throttle > cfg_thr_cut) begin
      thr_lock = 1'b1;
      thr_cnt  = '0;
    end else if (thr_lock) begin
      if (delay_elapsed(thr_cnt, cfg_thr_release)) thr_lock = 1'b0;
    end else begin
      thr_cnt = '0;
    end

    // rpm counter keeps running while in range, locked or not
    if (int'(t.rpm) < min_rpm || t.rpm_div100 > cfg_max_rpm100) begin
      rpm_lock = 1'b1;
      rpm_cnt  = '0;
    end else if (delay_elapsed(rpm_cnt, cfg_rpm_release)) begin
      rpm_lock = 1'b0;
    end

    if (t.ac_request && warmed_up && !cool_lock && !thr_lock && !rpm_lock) begin
      accepted = 1'b1;
      fan_flag = 1'b1;
      if (delay_elapsed(comp_cnt, cfg_comp_delay)) comp_flag = 1'b1;
    end else begin
      fan_flag  = 1'b0;
      comp_flag = 1'b0;
      comp_cnt  = '0;
    end

    r.compressor_on    = comp_flag;
    r.fan_on           = fan_flag;
    r.turning_on       = accepted;
    r.coolant_lockout  = cool_lock;
    r.throttle_lockout = thr_lock;
    r.rpm_lockout      = rpm_lock;
    return r;
  endfunction

  // Mostly short idle periods, a few long ones
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one tick; the expectation is logged at the transfer edge
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_bus.valid          <= 1'b1;
    tick_bus.coolant_temp   <= t.coolant_temp;
    tick_bus.throttle       <= t.throttle;
    tick_bus.rpm            <= t.rpm;
    tick_bus.rpm_div100     <= t.rpm_div100;
    tick_bus.engine_running <= t.engine_running;
    tick_bus.ac_request     <= t.ac_request;
    do @(posedge clk_i); while (tick_bus.ready !== 1'b1);
    predicted_drive.push_back(predict_drive(t));
  endtask

  task automatic send_values(input int temp, input int thr, input int rpm,
                             input int rpm100, input bit running, input bit request);
    tick_t t;
    t.coolant_temp   = TempW'(temp);
    t.throttle       = ByteW'(thr);
    t.rpm            = RpmW'(rpm);
    t.rpm_div100     = ByteW'(rpm100);
    t.engine_running = running;
    t.ac_request     = request;
    send_tick(t);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_for_results();
    @(negedge clk_i);
    tick_bus.valid <= 1'b0;
    while (predicted_drive.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup then access phase
  task automatic write_reg(input reg_idx_e idx, input logic [TempW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      RegCoolantCut:   cfg_cool_cut    = value;
      RegThrottleCut:  cfg_thr_cut     = value[ByteW-1:0];
      RegMinRpmDiv10:  cfg_min_rpm10   = value[ByteW-1:0];
      RegMaxRpmDiv100: cfg_max_rpm100  = value[ByteW-1:0];
      RegCompOnDelay:  cfg_comp_delay  = value[ByteW-1:0];
      RegThrRelDelay:  cfg_thr_release = value[ByteW-1:0];
      RegRpmRelDelay:  cfg_rpm_release = value[ByteW-1:0];
      RegStartDelay:   cfg_start_delay = value[ByteW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input int cut, input int thr, input int min10, input int max100,
                              input int comp, input int thr_rel, input int rpm_rel,
                              input int start);
    write_reg(RegCoolantCut, TempW'(cut));
    write_reg(RegThrottleCut, TempW'(thr));
    write_reg(RegMinRpmDiv10, TempW'(min10));
    write_reg(RegMaxRpmDiv100, TempW'(max100));
    write_reg(RegCompOnDelay, TempW'(comp));
    write_reg(RegThrRelDelay, TempW'(thr_rel));
    write_reg(RegRpmRelDelay, TempW'(rpm_rel));
    write_reg(RegStartDelay, TempW'(start));
  endtask

  task automatic apply_random_config(input int unsigned max_delay);
    int cut;
    // now and then a cut temperature outside the documented range
    if ($urandom_range(0, 9) == 0) cut = int'($signed(TempW'($urandom)));
    else cut = -40 + int'($urandom_range(0, 255));
    apply_config(cut, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, max_delay), $urandom_range(0, max_delay),
                 $urandom_range(0, max_delay), $urandom_range(0, max_delay));
  endtask

  // Mostly in-range ticks for the current setting, with some noise per field
  function automatic tick_t gen_tick();
    tick_t t;
    int    lo;
    int    hi;
    int    min_rpm;
    min_rpm = int'(cfg_min_rpm10) * 10;

    hi = int'($signed(cfg_cool_cut)) - 2;
    lo = (hi >= -40) ? -40 : -256;
    if ($urandom_range(0, 99) < noise_pct) begin
      if ($urandom_range(0, 2) == 0) t.coolant_temp = TempW'($urandom);
      else t.coolant_temp = TempW'(int'($signed(cfg_cool_cut)) + int'($urandom_range(0, 2)) - 1);
    end else if (hi < lo) begin
      t.coolant_temp = TempW'(-256);
    end else begin
      t.coolant_temp = TempW'(lo + int'($urandom_range(0, hi - lo)));
    end

    if ($urandom_range(0, 99) < noise_pct)
      t.throttle = $urandom_range(0, 1) ? ByteW'($urandom) : ByteW'(cfg_thr_cut + 8'd1);
    else
      t.throttle = ByteW'($urandom_range(0, cfg_thr_cut));

    if ($urandom_range(0, 99) < noise_pct)
      t.rpm = $urandom_range(0, 1) ? RpmW'($urandom) : RpmW'(min_rpm - 1);
    else
      t.rpm = RpmW'(min_rpm + int'($urandom_range(0, 25500 - min_rpm)));

    if ($urandom_range(0, 99) < noise_pct)
      t.rpm_div100 = $urandom_range(0, 1) ? ByteW'($urandom) : ByteW'(cfg_max_rpm100 + 8'd1);
    else
      t.rpm_div100 = ByteW'($urandom_range(0, cfg_max_rpm100));

    t.engine_running = ($urandom_range(0, 99) >= noise_pct / 2);
    t.ac_request     = ($urandom_range(0, 99) >= noise_pct);
    return t;
  endfunction

  task automatic run_phase(input int unsigned count, input int unsigned noise, input bit gaps);
    noise_pct = noise;
    gaps_on   = gaps;
    repeat (count) send_tick(gen_tick());
  endtask

  // Compare one output field
  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      err_count++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && drive_bus.valid === 1'b1 && drive_bus.ready === 1'b1) begin
      if (predicted_drive.size() == 0) begin
        $error("result transfer with no tick outstanding");
        err_count++;
      end else begin
        want_drive = predicted_drive.pop_front();
        check_field("compressor_on", want_drive.compressor_on, drive_bus.compressor_on);
        check_field("fan_on", want_drive.fan_on, drive_bus.fan_on);
        check_field("turning_on", want_drive.turning_on, drive_bus.turning_on);
        check_field("coolant_lockout", want_drive.coolant_lockout, drive_bus.coolant_lockout);
        check_field("throttle_lockout", want_drive.throttle_lockout,
                    drive_bus.throttle_lockout);
        check_field("rpm_lockout", want_drive.rpm_lockout, drive_bus.rpm_lockout);
      end
    end
  end

  // Result side back-pressure
  initial begin
    int unsigned stall_left;
    stall_left      = 0;
    drive_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        drive_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        drive_bus.ready <= 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Reset settings: basic acceptance, request and running gating
  task automatic test_default_config();
    send_values(20, 0, 1000, 10, 1'b1, 1'b1);
    send_values(-40, 0, 500, 60, 1'b1, 1'b1);
    send_values(20, 0, 1000, 10, 1'b1, 1'b0);
    send_values(20, 0, 1000, 10, 1'b0, 1'b1);
  endtask

  // Coolant lockout and its hysteresis band
  task automatic test_coolant_band();
    send_values(255, 0, 1000, 10, 1'b1, 1'b1);
    send_values(100, 0, 1000, 10, 1'b1, 1'b1);
    send_values(99, 0, 1000, 10, 1'b1, 1'b1);
    send_values(98, 0, 1000, 10, 1'b1, 1'b1);
    send_values(-256, 0, 1000, 10, 1'b1, 1'b1);
  endtask

  // Throttle and rpm lockouts with zero release delays
  task automatic test_throttle_rpm();
    send_values(20, 255, 1000, 10, 1'b1, 1'b1);
    send_values(20, 180, 1000, 10, 1'b1, 1'b1);
    send_values(20, 0, 499, 10, 1'b1, 1'b1);
    send_values(20, 0, 32767, 255, 1'b1, 1'b1);
    send_values(20, 0, 1000, 10, 1'b1, 1'b1);
  endtask

  // Non-zero delays, then the on-delay raised while the compressor runs
  task automatic test_delays();
    wait_for_results();
    apply_config(100, 180, 50, 60, 2, 2, 1, 2);
    repeat (5) send_values(20, 0, 1000, 10, 1'b1, 1'b1);
    wait_for_results();
    write_reg(RegCompOnDelay, TempW'(9));
    repeat (2) send_values(20, 0, 1000, 10, 1'b1, 1'b1);
    send_values(20, 200, 1000, 10, 1'b1, 1'b1);
    repeat (3) send_values(20, 0, 1000, 10, 1'b1, 1'b1);
  endtask

  // Random ticks across several settings, extremes included
  task automatic test_random_ticks();
    wait_for_results();
    apply_random_config(6);
    run_phase(250, 8, 1'b1);

    wait_for_results();
    apply_config(-40, 0, 0, 0, 0, 0, 0, 0);
    run_phase(150, 10, 1'b1);

    // longest delays need an unbroken run of healthy ticks
    wait_for_results();
    apply_config(215, 255, 255, 255, 255, 255, 255, 255);
    run_phase(540, 0, 1'b1);

    wait_for_results();
    apply_random_config(12);
    run_phase(150, 15, 1'b0);

    wait_for_results();
    apply_random_config(4);
    run_phase(75, 10, 1'b1);
    wait_for_results();
    run_phase(75, 10, 1'b1);
  endtask

  initial begin
    reset_model();
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    tick_bus.valid          = 1'b0;
    tick_bus.coolant_temp   = '0;
    tick_bus.throttle       = '0;
    tick_bus.rpm            = '0;
    tick_bus.rpm_div100     = '0;
    tick_bus.engine_running = 1'b0;
    tick_bus.ac_request     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_config();
    test_coolant_band();
    test_throttle_rpm();
    test_delays();
    test_random_ticks();
    wait_for_results();

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
